### design/hcc_pkg.sv
// shared widths, opcodes and pipeline word types for the hilbert curve converter
package hcc_pkg;

	localparam int MAX_ORDER_DEF = 16;
	localparam int ORDER_W       = 5;
	localparam int COORD_W       = 16;
	localparam int DIST_W        = 32;
	localparam int WIDE_W        = 64;

	localparam logic OP_D2XY = 1'b0;
	localparam logic OP_XY2D = 1'b1;

	typedef struct packed {
		logic               op;
		logic               par;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [DIST_W-1:0]  w;
	} hcc_word_t;

	typedef struct packed {
		logic               op;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [DIST_W-1:0]  distance;
	} hcc_res_t;

endpackage

### design/hcc_in_if.sv
// request channel: opcode, order and operands with valid/ready
interface hcc_in_if import hcc_pkg::*;;
	logic               valid;
	logic               ready;
	logic               opcode;
	logic [ORDER_W-1:0] curve_order;
	logic [DIST_W-1:0]  dist_in;
	logic [COORD_W-1:0] coord_x_in;
	logic [COORD_W-1:0] coord_y_in;

	modport source (
		output valid, opcode, curve_order, dist_in, coord_x_in, coord_y_in,
		input  ready
	);

	modport sink (
		input  valid, opcode, curve_order, dist_in, coord_x_in, coord_y_in,
		output ready
	);
endinterface

### design/hcc_out_if.sv
// result channel: position and distance with valid/ready
interface hcc_out_if import hcc_pkg::*;;
	logic               valid;
	logic               ready;
	logic [COORD_W-1:0] coord_x_out;
	logic [COORD_W-1:0] coord_y_out;
	logic [DIST_W-1:0]  dist_out;

	modport source (
		output valid, coord_x_out, coord_y_out, dist_out,
		input  ready
	);

	modport sink (
		input  valid, coord_x_out, coord_y_out, dist_out,
		output ready
	);
endinterface

### design/hilbert_curve_converter_core.sv
// hilbert curve converter top level: entry stage, one stage per level, result register
//
// channel  modport  payload
// req      sink     opcode, curve_order, dist_in, coord_x_in, coord_y_in
// rsp      source   coord_x_out, coord_y_out, dist_out
//
// one word accepted per cycle while the pipeline is not stalled by rsp.ready
// every level of the curve has its own register stage, all levels always run
// arst_n clears the stage valid bits only
// a stage holds while the stage after it is full and stalled, empty stages fill
module hilbert_curve_converter_core import hcc_pkg::*; #(
	parameter int MAX_ORDER = MAX_ORDER_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	hcc_in_if.sink           req,
	hcc_out_if.source        rsp
);

	localparam int   LAST    = MAX_ORDER + 1;
	localparam logic MAX_PAR = 1'(MAX_ORDER % 2);

	hcc_word_t          word_s [0:MAX_ORDER];
	hcc_word_t          lvl_out [1:MAX_ORDER];
	logic               valid_s [0:LAST];
	logic               adv [0:LAST];
	hcc_res_t           res_s;
	hcc_word_t          entry;
	hcc_res_t           res;
	logic [ORDER_W-1:0] k;
	logic [COORD_W-1:0] cmask;
	logic [DIST_W-1:0]  dmask;
	logic [COORD_W-1:0] xm;
	logic [COORD_W-1:0] ym;

	// entry: saturate order, drop operand bits above it, pre-swap for unused levels
	always_comb begin
		k = (req.curve_order > ORDER_W'(MAX_ORDER)) ? ORDER_W'(MAX_ORDER) : req.curve_order;
		cmask = COORD_W'((WIDE_W'(1) << k) - WIDE_W'(1));
		dmask = DIST_W'((WIDE_W'(1) << {k, 1'b0}) - WIDE_W'(1));
		xm = req.coord_x_in & cmask;
		ym = req.coord_y_in & cmask;
		entry.op  = req.opcode;
		entry.par = k[0] ^ MAX_PAR;
		if (req.opcode == OP_D2XY) begin
			entry.x = '0;
			entry.y = '0;
			entry.w = req.dist_in & dmask;
		end else begin
			entry.x = entry.par ? ym : xm;
			entry.y = entry.par ? xm : ym;
			entry.w = '0;
		end
	end

	// stall chain
	always_comb begin
		adv[LAST] = !valid_s[LAST] || rsp.ready;
		for (int j = LAST - 1; j >= 0; j--) begin
			adv[j] = !valid_s[j] || adv[j+1];
		end
	end

	assign req.ready = adv[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s[0] <= 1'b0;
		end else if (adv[0]) begin
			valid_s[0] <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			word_s[0] <= entry;
		end
	end

	for (genvar j = 1; j <= MAX_ORDER; j++) begin : g_lvl
		hcc_level #(
			.MAX_ORDER (MAX_ORDER),
			.STEP      (j - 1)
		) u_level (
			.cur (word_s[j-1]),
			.nxt (lvl_out[j])
		);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[j] <= 1'b0;
			end else if (adv[j]) begin
				valid_s[j] <= valid_s[j-1];
			end
		end

		always_ff @(posedge clk) begin
			if (adv[j]) begin
				word_s[j] <= lvl_out[j];
			end
		end
	end

	// undo the swaps of unused levels, zero the unused field
	always_comb begin
		res.op = word_s[MAX_ORDER].op;
		if (word_s[MAX_ORDER].op == OP_D2XY) begin
			res.x        = word_s[MAX_ORDER].par ? word_s[MAX_ORDER].y : word_s[MAX_ORDER].x;
			res.y        = word_s[MAX_ORDER].par ? word_s[MAX_ORDER].x : word_s[MAX_ORDER].y;
			res.distance = '0;
		end else begin
			res.x        = '0;
			res.y        = '0;
			res.distance = word_s[MAX_ORDER].w;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s[LAST] <= 1'b0;
		end else if (adv[LAST]) begin
			valid_s[LAST] <= valid_s[MAX_ORDER];
		end
	end

	always_ff @(posedge clk) begin
		if (adv[LAST]) begin
			res_s <= res;
		end
	end

	assign rsp.valid       = valid_s[LAST];
	assign rsp.coord_x_out = res_s.x;
	assign rsp.coord_y_out = res_s.y;
	assign rsp.dist_out    = res_s.distance;

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> valid_s[0])
		else $error("accepted word did not enter the pipeline");

	a_entry_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s[0] && !adv[0] |=> valid_s[0] && $stable(word_s[0]))
		else $error("stalled entry stage changed");

	a_xy2d_zero_pos: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && res_s.op == OP_XY2D |-> rsp.coord_x_out == '0 && rsp.coord_y_out == '0)
		else $error("position not zero on a distance result");

	a_d2xy_zero_dist: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && res_s.op == OP_D2XY |-> rsp.dist_out == '0)
		else $error("distance not zero on a position result");

endmodule

### design/hcc_level.sv
// one curve level: rotate, reflect and accumulate for either direction
module hcc_level import hcc_pkg::*; #(
	parameter int MAX_ORDER = MAX_ORDER_DEF,
	parameter int STEP      = 0
) (
	input  hcc_word_t cur,
	output hcc_word_t nxt
);

	localparam int LVL_D = STEP;
	localparam int LVL_P = MAX_ORDER - 1 - STEP;
	localparam logic [COORD_W-1:0] MASK_D =
		COORD_W'((WIDE_W'(1) << LVL_D) - WIDE_W'(1));
	localparam logic [COORD_W-1:0] MASK_P =
		COORD_W'((WIDE_W'(1) << LVL_P) - WIDE_W'(1));

	logic [WIDE_W-1:0]  dwide;
	logic [WIDE_W-1:0]  xwide;
	logic [WIDE_W-1:0]  ywide;
	logic               rx;
	logic               ry;
	logic [1:0]         quad;
	logic [COORD_W-1:0] xa;
	logic [COORD_W-1:0] ya;

	always_comb begin
		nxt   = cur;
		dwide = WIDE_W'(cur.w);
		xwide = WIDE_W'(cur.x);
		ywide = WIDE_W'(cur.y);
		rx    = 1'b0;
		ry    = 1'b0;
		quad  = 2'b00;
		xa    = cur.x;
		ya    = cur.y;
		if (cur.op == OP_D2XY) begin
			// finest level first
			rx = dwide[2*LVL_D+1];
			ry = dwide[2*LVL_D] ^ rx;
			if (rx && !ry) begin
				xa = cur.x ^ MASK_D;
				ya = cur.y ^ MASK_D;
			end
			if (!ry) begin
				nxt.x = ya;
				nxt.y = xa;
			end else begin
				nxt.x = xa;
				nxt.y = ya;
			end
			nxt.x = nxt.x | COORD_W'(WIDE_W'(rx) << LVL_D);
			nxt.y = nxt.y | COORD_W'(WIDE_W'(ry) << LVL_D);
		end else begin
			// coarsest level first
			rx    = xwide[LVL_P];
			ry    = ywide[LVL_P];
			quad  = {rx, rx ^ ry};
			nxt.w = cur.w | DIST_W'(WIDE_W'(quad) << (2*LVL_P));
			xa    = cur.x & MASK_P;
			ya    = cur.y & MASK_P;
			if (rx && !ry) begin
				xa = xa ^ MASK_P;
				ya = ya ^ MASK_P;
			end
			if (!ry) begin
				nxt.x = ya;
				nxt.y = xa;
			end else begin
				nxt.x = xa;
				nxt.y = ya;
			end
		end
	end

endmodule

### verif/hcc_conv_checker.sv
// checker for the hilbert curve converter: predicts each result word and compares it
module hcc_conv_checker import hcc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	hcc_in_if    req,
	hcc_out_if   rsp,
	output int   pending,
	output int   mismatches
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [DIST_W-1:0]  distance;
	} hcc_expect_t;

	hcc_expect_t expected_q[$];
	int          mismatch_cnt = 0;

	function automatic int unsigned clamp_level(logic [ORDER_W-1:0] order);
		return (order > MAX_ORDER_DEF) ? MAX_ORDER_DEF : int'(order);
	endfunction

	function automatic hcc_expect_t dist_to_cell(logic [ORDER_W-1:0] order,
			logic [DIST_W-1:0] dist_val);
		int unsigned levels, lvl, side, cx, cy, tmp;
		bit [DIST_W-1:0] rest;
		bit rx, ry;
		hcc_expect_t pos;
		levels = clamp_level(order);
		cx     = 0;
		cy     = 0;
		rest   = dist_val;
		for (lvl = 0; lvl < levels; lvl++) begin
			side = 1 << lvl;
			rx   = rest[1];
			ry   = rest[0] ^ rest[1];
			if (!ry) begin
				if (rx) begin
					cx = side - 1 - cx;
					cy = side - 1 - cy;
				end
				tmp = cx;
				cx  = cy;
				cy  = tmp;
			end
			cx   = cx + (rx ? side : 0);
			cy   = cy + (ry ? side : 0);
			rest = rest >> 2;
		end
		pos.x        = cx[COORD_W-1:0];
		pos.y        = cy[COORD_W-1:0];
		pos.distance = '0;
		return pos;
	endfunction

	function automatic hcc_expect_t cell_to_dist(logic [ORDER_W-1:0] order,
			logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
		int unsigned levels, side, cx, cy, tmp;
		int lvl;
		bit rx, ry;
		bit [1:0] quad;
		bit [WIDE_W-1:0] acc;
		hcc_expect_t pos;
		levels = clamp_level(order);
		acc    = '0;
		cx     = int'(x) & ((1 << levels) - 1);
		cy     = int'(y) & ((1 << levels) - 1);
		for (lvl = int'(levels) - 1; lvl >= 0; lvl--) begin
			side = 1 << lvl;
			rx   = cx[lvl];
			ry   = cy[lvl];
			quad = {rx, rx ^ ry};
			acc  = acc + (WIDE_W'(quad) << (2 * lvl));
			cx   = cx & (side - 1);
			cy   = cy & (side - 1);
			if (!ry) begin
				if (rx) begin
					cx = side - 1 - cx;
					cy = side - 1 - cy;
				end
				tmp = cx;
				cx  = cy;
				cy  = tmp;
			end
		end
		pos.x        = '0;
		pos.y        = '0;
		pos.distance = acc[DIST_W-1:0];
		return pos;
	endfunction

	always @(posedge clk) begin
		hcc_expect_t want;
		if (arst_n) begin
			if (rsp.valid && rsp.ready) begin
				if (expected_q.size() == 0) begin
					$error("result word with nothing expected: x %0h y %0h dist %0h",
						rsp.coord_x_out, rsp.coord_y_out, rsp.dist_out);
					mismatch_cnt++;
				end else begin
					want = expected_q.pop_front();
					if (rsp.coord_x_out !== want.x) begin
						$error("coord_x_out: expected %0h, got %0h", want.x, rsp.coord_x_out);
						mismatch_cnt++;
					end
					if (rsp.coord_y_out !== want.y) begin
						$error("coord_y_out: expected %0h, got %0h", want.y, rsp.coord_y_out);
						mismatch_cnt++;
					end
					if (rsp.dist_out !== want.distance) begin
						$error("dist_out: expected %0h, got %0h", want.distance,
							rsp.dist_out);
						mismatch_cnt++;
					end
				end
			end
			if (req.valid && req.ready) begin
				if (req.opcode == OP_D2XY)
					expected_q.push_back(dist_to_cell(req.curve_order, req.dist_in));
				else
					expected_q.push_back(cell_to_dist(req.curve_order, req.coord_x_in,
						req.coord_y_in));
			end
		end
		pending    <= expected_q.size();
		mismatches <= mismatch_cnt;
	end

endmodule

### verif/hilbert_curve_converter_core_tb.sv
// testbench top for the hilbert curve converter: stimulus, receiver pacing and verdict
module hilbert_curve_converter_core_tb import hcc_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_PER_PHASE = 410;
	localparam int LONG_HOLD        = 300;
	localparam int IDLE_LIMIT       = 3000;

	logic clk;
	logic arst_n;
	int   pending;
	int   mismatches;
	int   tx_idle_pct;
	int   rx_idle_pct;
	int   hold_asks;
	int   hold_done;
	int   idle_cycles = 0;

	hcc_in_if  req_if ();
	hcc_out_if rsp_if ();

	hilbert_curve_converter_core i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	hcc_conv_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req_if),
		.rsp        (rsp_if),
		.pending    (pending),
		.mismatches (mismatches)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// receiver pacing, with a long hold-off whenever one is asked for
	initial begin
		rsp_if.ready = 1'b0;
		hold_done    = 0;
		forever begin
			@(negedge clk);
			if (hold_asks != hold_done) begin
				hold_done++;
				rsp_if.ready <= 1'b0;
				repeat (LONG_HOLD - 1) @(negedge clk);
			end else begin
				rsp_if.ready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic push_word(input logic op, input logic [ORDER_W-1:0] order,
			input logic [DIST_W-1:0] dist_val, input logic [COORD_W-1:0] x,
			input logic [COORD_W-1:0] y);
		while ($urandom_range(99) < tx_idle_pct) begin
			req_if.valid <= 1'b0;
			@(posedge clk);
			@(negedge clk);
		end
		req_if.valid       <= 1'b1;
		req_if.opcode      <= op;
		req_if.curve_order <= order;
		req_if.dist_in     <= dist_val;
		req_if.coord_x_in  <= x;
		req_if.coord_y_in  <= y;
		@(posedge clk);
		while (!req_if.ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic push_random();
		logic [ORDER_W-1:0] order;
		if ($urandom_range(9) == 0)
			order = ORDER_W'($urandom_range(31));
		else
			order = ORDER_W'($urandom_range(MAX_ORDER_DEF));
		push_word($urandom_range(1) ? OP_XY2D : OP_D2XY, order, $urandom,
			COORD_W'($urandom_range(16'hffff)), COORD_W'($urandom_range(16'hffff)));
	endtask

	task automatic drain();
		req_if.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		@(negedge clk);
	endtask

	initial begin
		arst_n             = 1'b0;
		req_if.valid       = 1'b0;
		req_if.opcode      = OP_D2XY;
		req_if.curve_order = '0;
		req_if.dist_in     = '0;
		req_if.coord_x_in  = '0;
		req_if.coord_y_in  = '0;
		tx_idle_pct        = 38;
		rx_idle_pct        = 46;
		hold_asks          = 0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// corners: single cell, full order, saturated order, stray upper bits
		push_word(OP_D2XY, 5'd0,  32'hffff_ffff, 16'($urandom), 16'($urandom));
		push_word(OP_XY2D, 5'd0,  $urandom,      16'hffff,      16'hffff);
		push_word(OP_D2XY, 5'd16, 32'h0000_0000, 16'hffff,      16'hffff);
		push_word(OP_D2XY, 5'd16, 32'hffff_ffff, 16'h0000,      16'h0000);
		push_word(OP_XY2D, 5'd16, 32'hffff_ffff, 16'h0000,      16'h0000);
		push_word(OP_XY2D, 5'd16, 32'h0000_0000, 16'hffff,      16'hffff);
		push_word(OP_XY2D, 5'd16, $urandom,      16'hffff,      16'h0000);
		push_word(OP_XY2D, 5'd16, $urandom,      16'h0000,      16'hffff);
		push_word(OP_D2XY, 5'd31, 32'ha5a5_a5a5, 16'($urandom), 16'($urandom));
		push_word(OP_XY2D, 5'd31, $urandom,      16'h1234,      16'hfedc);
		push_word(OP_D2XY, 5'd17, 32'hffff_ffff, 16'($urandom), 16'($urandom));
		push_word(OP_D2XY, 5'd1,  32'hffff_ffff, 16'($urandom), 16'($urandom));
		push_word(OP_XY2D, 5'd1,  $urandom,      16'hffff,      16'hfffe);
		push_word(OP_D2XY, 5'd8,  32'hffff_0123, 16'($urandom), 16'($urandom));
		push_word(OP_XY2D, 5'd8,  $urandom,      16'hff80,      16'h007f);
		push_word(OP_D2XY, 5'd15, 32'h5555_5555, 16'($urandom), 16'($urandom));
		push_word(OP_XY2D, 5'd15, $urandom,      16'haaaa,      16'h5555);
		push_word(OP_D2XY, 5'd16, 32'haaaa_aaaa, 16'($urandom), 16'($urandom));
		push_word(OP_XY2D, 5'd16, $urandom,      16'h5555,      16'haaaa);
		push_word(OP_D2XY, 5'd2,  32'h0000_0007, 16'($urandom), 16'($urandom));
		push_word(OP_XY2D, 5'd3,  $urandom,      16'h0005,      16'h0006);

		for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
			if (i == RANDOM_PER_PHASE / 3)
				hold_asks <= hold_asks + 1;
			push_random();
		end
		drain();

		tx_idle_pct = 46;
		rx_idle_pct = 38;
		for (int i = 0; i < RANDOM_PER_PHASE; i++)
			push_random();
		drain();

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		for (int i = 0; i < RANDOM_PER_PHASE; i++)
			push_random();
		drain();

		repeat (MAX_ORDER_DEF + 8) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

### filelist.f
design/hcc_pkg.sv
design/hcc_in_if.sv
design/hcc_out_if.sv
design/hcc_level.sv
design/hilbert_curve_converter_core.sv
verif/hcc_conv_checker.sv
verif/hilbert_curve_converter_core_tb.sv
